/* hdl/assert_macros.svh */
// Assertion macros shared by the lexer RTL.
// Depends on nothing; files take it by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SCL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SCL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SCL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SCL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/scl_pkg.sv */
// Types, codes and kind tables of the source character lexer.
// Used by every lexer module; depends on nothing.
`timescale 1ns / 1ps
package scl_pkg;

  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = 2;
  localparam int unsigned QCntW   = 3;
  localparam logic [15:0] LenMax  = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_WORD    = 2'd1,
    MODE_NUMBER  = 2'd2,
    MODE_COMMENT = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_PLUS  = 3'd1,
    OP_MINUS = 3'd2,
    OP_STAR  = 3'd3,
    OP_SLASH = 3'd4,
    OP_GT    = 3'd5,
    OP_LT    = 3'd6,
    OP_BANG  = 3'd7
  } op_e;

  typedef enum logic [4:0] {
    KIND_NUMBER   = 5'd0,
    KIND_SPACE    = 5'd1,
    KIND_TAB      = 5'd2,
    KIND_EOL      = 5'd3,
    KIND_EQUALS   = 5'd4,
    KIND_PLUS     = 5'd5,
    KIND_MINUS    = 5'd6,
    KIND_STAR     = 5'd7,
    KIND_SLASH    = 5'd8,
    KIND_GT       = 5'd9,
    KIND_LT       = 5'd10,
    KIND_GE       = 5'd11,
    KIND_LE       = 5'd12,
    KIND_PLUS_EQ  = 5'd13,
    KIND_MINUS_EQ = 5'd14,
    KIND_STAR_EQ  = 5'd15,
    KIND_SLASH_EQ = 5'd16,
    KIND_NE       = 5'd17,
    KIND_BANG     = 5'd18,
    KIND_COMMENT  = 5'd19,
    KIND_WORD     = 5'd20
  } kind_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] span_len;
    logic        run_end;
  } out_t;

  // All words caused by one input byte
  typedef struct packed {
    logic [1:0]       count;
    out_t [1:0]       toks;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  function automatic kind_e single_kind(op_e op);
    kind_e k;
    unique case (op)
      OP_PLUS:  k = KIND_PLUS;
      OP_MINUS: k = KIND_MINUS;
      OP_STAR:  k = KIND_STAR;
      OP_SLASH: k = KIND_SLASH;
      OP_GT:    k = KIND_GT;
      OP_LT:    k = KIND_LT;
      OP_BANG:  k = KIND_BANG;
      default:  k = KIND_NUMBER;
    endcase
    return k;
  endfunction

  function automatic kind_e compound_kind(op_e op);
    kind_e k;
    unique case (op)
      OP_PLUS:  k = KIND_PLUS_EQ;
      OP_MINUS: k = KIND_MINUS_EQ;
      OP_STAR:  k = KIND_STAR_EQ;
      OP_SLASH: k = KIND_SLASH_EQ;
      OP_GT:    k = KIND_GE;
      OP_LT:    k = KIND_LE;
      OP_BANG:  k = KIND_NE;
      default:  k = KIND_NUMBER;
    endcase
    return k;
  endfunction

  function automatic kind_e open_kind(mode_e m);
    kind_e k;
    unique case (m)
      MODE_WORD:   k = KIND_WORD;
      MODE_NUMBER: k = KIND_NUMBER;
      default:     k = KIND_COMMENT;
    endcase
    return k;
  endfunction

  function automatic out_t make_tok(kind_e kind, logic [15:0] start, logic [15:0] len);
    out_t t;
    t.token_kind = kind;
    t.start_pos  = start;
    t.span_len   = len;
    t.run_end    = 1'b0;
    return t;
  endfunction

endpackage

/* hdl/source_char_lexer.sv */
// Source character lexer: one source byte in, tokens out one per cycle while not stalled.
// Input word: byte_in and end_of_source; accepted when in_valid_i is high and
// in_stall_o is low. Output word: token_kind, start_pos, span_len, run_end;
// taken when out_valid_o is high and out_stall_i is low.
// Each byte causes zero, one or two tokens; run_end marks the last token of
// a byte, and end_of_source flushes any open token and held operator and
// restarts positions at zero for the next source.
// Path: an accepted byte's bundle is written into the bundle queue, and its first
// token is then loaded into the output register once that register is free.
// Throughput: one byte per cycle while bytes cause at most one token and the
// receiver does not stall; a byte with two tokens passes them one after the other
// through the single output register. The four-entry bundle queue absorbs such
// bursts; when it is full in_stall_o rises. An operator byte yields its token only
// when the next byte arrives or when it carries end_of_source itself. A stalled
// receiver holds the output word; the front keeps taking bytes until the queue fills.
// Reset: lexer mode normal, position zero, no held operator, queue and output
// empty. No clearing pass is needed.
// Depends on scl_pkg, scl_front, scl_queue, scl_back and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module source_char_lexer #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  scl_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output scl_pkg::out_t  out_data_o
);

  logic              q_push;
  logic              q_pop;
  scl_pkg::bundle_t  q_bundle;
  scl_pkg::bundle_t  q_head;
  scl_pkg::q_stat_t  q_stat;
  logic              split_take;

  scl_front #(
    .POS_WIDTH (POS_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .bundle_o   (q_bundle)
  );

  scl_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .bundle_i (q_bundle),
    .pop_i    (q_pop),
    .head_o   (q_head),
    .stat_o   (q_stat)
  );

  scl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .q_stat_i    (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Flag a taken token that is not the last of its byte
  assign split_take = out_valid_o && !out_stall_i && !out_data_o.run_end;

  // Never pop an empty queue, never push an empty bundle
  `SCL_ASSERT_IMPL(a_pop_valid, clk_i, rst_ni, q_pop, q_stat.valid, "pop from empty queue")
  `SCL_ASSERT_IMPL(a_push_count, clk_i, rst_ni, q_push, q_bundle.count != 2'd0, "empty push")
  // A taken token without run_end is followed at once by the rest of its byte
  `SCL_ASSERT_NEXT(a_run_follow, clk_i, rst_ni, split_take, out_valid_o, "second token missing")

endmodule

/* hdl/scl_front.sv */
// Lexer front end: accepts bytes, keeps lexer state, builds word bundles.
// Depends on scl_pkg.
`timescale 1ns / 1ps
module scl_front #(
  parameter int unsigned POS_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  scl_pkg::in_t      in_data_i,
  input  scl_pkg::q_stat_t  q_stat_i,
  output logic              push_o,
  output scl_pkg::bundle_t  bundle_o
);

  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;

  scl_pkg::mode_e         mode_q, mode_d;
  logic [POS_WIDTH-1:0]   pos_q, pos_d;
  logic [POS_WIDTH-1:0]   start_q, start_d;
  scl_pkg::op_e           held_q, held_d;
  logic                   lws_q, lws_d;
  logic [15:0]            cnt_q, cnt_d;
  logic                   accept;
  logic [1:0]             n;
  scl_pkg::out_t [1:0]    toks;

  function automatic logic [15:0] to_out(logic [POS_WIDTH-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[15:0];
  endfunction

  function automatic scl_pkg::op_e op_code(logic [7:0] b);
    scl_pkg::op_e op;
    unique case (b)
      ChPlus:  op = scl_pkg::OP_PLUS;
      ChMinus: op = scl_pkg::OP_MINUS;
      ChStar:  op = scl_pkg::OP_STAR;
      ChSlash: op = scl_pkg::OP_SLASH;
      ChGt:    op = scl_pkg::OP_GT;
      ChLt:    op = scl_pkg::OP_LT;
      ChBang:  op = scl_pkg::OP_BANG;
      default: op = scl_pkg::OP_NONE;
    endcase
    return op;
  endfunction

  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i && !q_stat_i.full;

  // Classify the byte and work out the next state and the words it causes
  always_comb begin
    logic [7:0]           b;
    logic                 last;
    logic [POS_WIDTH-1:0] pos;
    logic                 alpha;
    logic                 digit;
    logic                 blank;
    logic                 is_op;
    logic                 hash;
    logic                 consumed;
    b        = in_data_i.byte_in;
    last     = in_data_i.end_of_source;
    pos      = pos_q;
    alpha    = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    digit    = (b >= 8'h30 && b <= 8'h39);
    blank    = (b == ChSpace) || (b == ChTab) || (b == ChLf) || (b == ChCr);
    is_op    = (b == ChEq) || (op_code(b) != scl_pkg::OP_NONE);
    hash     = (b == ChHash);
    consumed = 1'b0;
    n        = 2'd0;
    toks     = '0;
    mode_d   = mode_q;
    start_d  = start_q;
    held_d   = held_q;
    lws_d    = lws_q;
    cnt_d    = cnt_q;

    // Resolve a held operator against this byte
    if (held_d != scl_pkg::OP_NONE) begin
      if (b == ChEq) begin
        toks[n[0]] = scl_pkg::make_tok(scl_pkg::compound_kind(held_d), to_out(start_d), 16'd0);
        consumed   = 1'b1;
      end else begin
        toks[n[0]] = scl_pkg::make_tok(scl_pkg::single_kind(held_d), to_out(start_d), 16'd0);
      end
      n      = n + 2'd1;
      lws_d  = 1'b0;
      held_d = scl_pkg::OP_NONE;
    end

    if (!consumed) begin
      if (mode_d == scl_pkg::MODE_COMMENT) begin
        // End a comment on newline only; end of source also flushes it below
        if (b == ChLf) begin
          toks[n[0]] = scl_pkg::make_tok(scl_pkg::KIND_COMMENT, to_out(start_d), cnt_d);
          n          = n + 2'd1;
          toks[n[0]] = scl_pkg::make_tok(scl_pkg::KIND_EOL, to_out(pos), 16'd0);
          n          = n + 2'd1;
          lws_d      = 1'b0;
          mode_d     = scl_pkg::MODE_NORMAL;
        end
      end else begin
        // Close an open word or number, and enter comment mode on a hash
        if (mode_d != scl_pkg::MODE_NORMAL && (blank || is_op || hash)) begin
          toks[n[0]] = scl_pkg::make_tok(scl_pkg::open_kind(mode_d), to_out(start_d), cnt_d);
          n          = n + 2'd1;
          lws_d      = 1'b0;
          mode_d     = scl_pkg::MODE_NORMAL;
          if (hash) begin
            mode_d  = scl_pkg::MODE_COMMENT;
            start_d = pos;
            cnt_d   = 16'd0;
          end
        end else if (mode_d == scl_pkg::MODE_NORMAL && hash) begin
          mode_d  = scl_pkg::MODE_COMMENT;
          start_d = pos;
          cnt_d   = 16'd0;
        end
        // Handle the byte outside any token
        if (mode_d == scl_pkg::MODE_NORMAL && !hash) begin
          if (alpha || digit) begin
            mode_d  = alpha ? scl_pkg::MODE_WORD : scl_pkg::MODE_NUMBER;
            start_d = pos;
            cnt_d   = 16'd0;
          end else if (b == ChSpace) begin
            if (!lws_d) begin
              toks[n[0]] = scl_pkg::make_tok(scl_pkg::KIND_SPACE, to_out(pos), 16'd0);
              n          = n + 2'd1;
              lws_d      = 1'b1;
            end
          end else if (b == ChTab) begin
            toks[n[0]] = scl_pkg::make_tok(scl_pkg::KIND_TAB, to_out(pos), 16'd0);
            n          = n + 2'd1;
            lws_d      = 1'b0;
          end else if (b == ChLf || b == ChCr) begin
            toks[n[0]] = scl_pkg::make_tok(scl_pkg::KIND_EOL, to_out(pos), 16'd0);
            n          = n + 2'd1;
            lws_d      = 1'b0;
          end else if (b == ChEq) begin
            toks[n[0]] = scl_pkg::make_tok(scl_pkg::KIND_EQUALS, to_out(pos), 16'd0);
            n          = n + 2'd1;
            lws_d      = 1'b0;
          end else if (is_op) begin
            held_d  = op_code(b);
            start_d = pos;
          end
        end
      end
      // Count token length, saturating
      if (mode_d != scl_pkg::MODE_NORMAL && cnt_d != scl_pkg::LenMax) begin
        cnt_d = cnt_d + 16'd1;
      end
    end

    pos_d = pos + POS_WIDTH'(1);

    // Flush at end of source and return to reset state
    if (last) begin
      if (mode_d != scl_pkg::MODE_NORMAL) begin
        toks[n[0]] = scl_pkg::make_tok(scl_pkg::open_kind(mode_d), to_out(start_d), cnt_d);
        n          = n + 2'd1;
      end
      if (held_d != scl_pkg::OP_NONE) begin
        toks[n[0]] = scl_pkg::make_tok(scl_pkg::single_kind(held_d), to_out(start_d), 16'd0);
        n          = n + 2'd1;
      end
      mode_d  = scl_pkg::MODE_NORMAL;
      pos_d   = '0;
      start_d = '0;
      held_d  = scl_pkg::OP_NONE;
      lws_d   = 1'b0;
      cnt_d   = 16'd0;
    end

    // Mark the last word of this byte
    if (n == 2'd1) begin
      toks[0].run_end = 1'b1;
    end else if (n == 2'd2) begin
      toks[1].run_end = 1'b1;
    end
  end

  assign push_o         = accept && (n != 2'd0);
  assign bundle_o.count = n;
  assign bundle_o.toks  = toks;

  // Advance lexer state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= scl_pkg::MODE_NORMAL;
      pos_q   <= '0;
      start_q <= '0;
      held_q  <= scl_pkg::OP_NONE;
      lws_q   <= 1'b0;
      cnt_q   <= 16'd0;
    end else if (accept) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      held_q  <= held_d;
      lws_q   <= lws_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* hdl/scl_queue.sv */
// Short bundle queue between lexer front end and output back end.
// Depends on scl_pkg.
`timescale 1ns / 1ps
module scl_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  scl_pkg::bundle_t  bundle_i,
  input  logic              pop_i,
  output scl_pkg::bundle_t  head_o,
  output scl_pkg::q_stat_t  stat_o
);

  scl_pkg::bundle_t                mem_q [scl_pkg::QDepth];
  logic [scl_pkg::QPtrW-1:0]       wr_ptr_q;
  logic [scl_pkg::QPtrW-1:0]       rd_ptr_q;
  logic [scl_pkg::QCntW-1:0]       cnt_q;

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == scl_pkg::QCntW'(scl_pkg::QDepth));
  assign stat_o.valid = (cnt_q != '0);

  // Store pushed bundles
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= bundle_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + scl_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + scl_pkg::QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + scl_pkg::QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - scl_pkg::QCntW'(1);
      end
    end
  end

endmodule

/* hdl/scl_back.sv */
// Lexer back end: splits bundles into single words on the output register.
// Depends on scl_pkg.
`timescale 1ns / 1ps
module scl_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scl_pkg::bundle_t  head_i,
  input  scl_pkg::q_stat_t  q_stat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output scl_pkg::out_t     out_data_o
);

  logic           out_valid_q, out_valid_d;
  scl_pkg::out_t  out_q, out_d;
  logic           sel_q, sel_d;
  logic           load;
  logic           take;
  logic           last_of_bundle;

  assign load           = !out_valid_q || !out_stall_i;
  assign take           = load && q_stat_i.valid;
  assign last_of_bundle = sel_q || (head_i.count == 2'd1);
  assign pop_o          = take && last_of_bundle;

  // Pick the next word of the head bundle
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    sel_d       = sel_q;
    if (take) begin
      out_valid_d = 1'b1;
      out_d       = head_i.toks[sel_q];
      sel_d       = !last_of_bundle;
    end else if (load) begin
      out_valid_d = 1'b0;
    end
  end

  // Hold the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sel_q       <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
